@@ hdl/apbt_pkg.sv @@
package apbt_pkg;

    localparam int WAKE_BUTTONS_DEF = 3;
    localparam int DEBOUNCE_MS_DEF  = 50;

    localparam int SCAN_MAX       = 3;
    localparam int ALARM_BITS     = 16;
    localparam int SIDE_BITS      = 8;
    localparam int PAGE_SHIFT     = 2;
    localparam int PAGE_SIZE      = 1 << PAGE_SHIFT;
    localparam int PAGE_MS        = 3000;
    localparam int MS_PER_SECOND  = 1000;
    localparam int BRIGHT_MIN     = 1;
    localparam int BRIGHT_MAX     = 100;

    typedef enum logic [2:0] {
        CFG_ENABLE     = 3'd0,
        CFG_BRIGHTNESS = 3'd1,
        CFG_TIMEOUT    = 3'd2,
        CFG_WAKE_COUNT = 3'd3,
        CFG_ACTIVE     = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TITLE_BUS   = 2'd0,
        TITLE_AUX   = 2'd1,
        TITLE_MIXED = 2'd2
    } title_t;

    typedef struct packed {
        logic [7:0] fault_bus;
        logic [7:0] fault_aux;
        logic       test_mode;
        logic       rebuild;
        logic [2:0] wake_levels;
    } in_word_t;

    typedef struct packed {
        logic [6:0] backlight_level;
        logic       alarm_shown;
        logic       alarm_refresh;
        logic [1:0] title_code;
        logic [1:0] page_index;
        logic [2:0] page_total;
        logic [2:0] entries_on_page;
        logic [3:0] entry_first;
        logic [3:0] entry_second;
        logic [3:0] entry_third;
        logic [3:0] entry_fourth;
    } out_word_t;

    typedef struct packed {
        logic       alarm_shown;
        logic [1:0] title_code;
        logic [1:0] page_index;
        logic [2:0] page_total;
        logic [2:0] entries_on_page;
        logic [3:0] entry_first;
        logic [3:0] entry_second;
        logic [3:0] entry_third;
        logic [3:0] entry_fourth;
    } page_view_t;

    function automatic logic [2:0] pages_of(input logic [4:0] total);
        logic [5:0] sum;
        sum = 6'(total) + 6'(PAGE_SIZE - 1);
        return 3'(sum >> PAGE_SHIFT);
    endfunction

endpackage

@@ hdl/apbt_page_view.sv @@
module apbt_page_view import apbt_pkg::*; (
    input  logic [ALARM_BITS-1:0] mask,
    input  logic [1:0]            page,
    input  logic [4:0]            total,
    output page_view_t            view
);

    logic [3:0] rank [ALARM_BITS];
    logic [3:0] ent [PAGE_SIZE];
    logic [4:0] first;
    logic [4:0] avail;
    logic [2:0] n;
    logic       side0;
    logic       mixed;

    // position of each set bit among the set bits below it
    always_comb begin
        for (int b = 0; b < ALARM_BITS; b++) begin
            rank[b] = 4'($countones(mask & ((16'd1 << b) - 16'd1)));
        end
    end

    always_comb begin
        first = {1'b0, page, 2'b00};
        avail = (total > first) ? (total - first) : 5'd0;
        n     = (avail > 5'(PAGE_SIZE)) ? 3'(PAGE_SIZE) : avail[2:0];
        for (int k = 0; k < PAGE_SIZE; k++) begin
            ent[k] = '0;
            for (int b = 0; b < ALARM_BITS; b++) begin
                if (mask[b] && rank[b] == first[3:0] + 4'(k)) begin
                    ent[k] = 4'(b);
                end
            end
        end
        side0 = ent[0][3];
        mixed = 1'b0;
        for (int k = 1; k < PAGE_SIZE; k++) begin
            if (3'(k) < n && ent[k][3] != side0) begin
                mixed = 1'b1;
            end
        end
        view.alarm_shown     = (total != 5'd0);
        view.page_index      = page;
        view.page_total      = pages_of(total);
        view.entries_on_page = n;
        if (n == 3'd0) begin
            view.title_code = TITLE_BUS;
        end else if (mixed) begin
            view.title_code = TITLE_MIXED;
        end else begin
            view.title_code = side0 ? TITLE_AUX : TITLE_BUS;
        end
        view.entry_first  = ent[0];
        view.entry_second = ent[1];
        view.entry_third  = ent[2];
        view.entry_fourth = ent[3];
    end

endmodule

@@ hdl/alarm_pager_backlight_timeout.sv @@
// Alarm pager and backlight timeout. One word on s_data is one millisecond tick and gives
// exactly one result word on m_data. A word can be taken in every clock cycle while m_ready
// does not stall the result; it passes an input register and is then worked combinationally
// against the pager, backlight and debounce state into the result register. The state loop
// (mask compare, 32-bit elapsed-time compares and the page view) is combinational from the
// state registers back to them, which sets the rate at one word per clock. Configuration
// writes on cfg_* are always accepted and must only be made while no word is in flight.
// There is no clearing pass after reset.
module alarm_pager_backlight_timeout import apbt_pkg::*; #(
    parameter int WAKE_BUTTONS = WAKE_BUTTONS_DEF,
    parameter int DEBOUNCE_MS  = DEBOUNCE_MS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int SCAN_N = (WAKE_BUTTONS < SCAN_MAX) ? WAKE_BUTTONS : SCAN_MAX;

    // configuration
    logic        enable_reg;
    logic [6:0]  brightness_reg;
    logic [11:0] timeout_reg;
    logic [1:0]  wake_count_reg;
    logic [2:0]  active_reg;

    // pipeline
    logic      in_valid_reg;
    in_word_t  in_data_reg;
    logic      m_valid_reg;
    out_word_t m_data_reg;
    out_word_t m_data_next;
    logic      out_free;
    logic      advance;

    // state
    logic [31:0]           time_reg, time_next;
    logic [ALARM_BITS-1:0] shown_reg, shown_next;
    logic [4:0]            total_reg, total_next;
    logic [1:0]            page_reg, page_next;
    logic [31:0]           ptimer_reg, ptimer_next;
    logic [31:0]           last_reg, last_next;
    logic                  light_reg, light_next;
    logic                  pressed_reg [SCAN_N];
    logic                  pressed_next [SCAN_N];
    logic [31:0]           btimer_reg [SCAN_N];
    logic [31:0]           btimer_next [SCAN_N];

    logic                  refresh;
    logic [ALARM_BITS-1:0] mask;
    logic [21:0]           timeout_ms;
    logic [6:0]            bright;
    page_view_t            view;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_free;
    assign advance   = in_valid_reg && out_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b1;
            brightness_reg <= 7'(BRIGHT_MAX);
            timeout_reg    <= '0;
            wake_count_reg <= 2'd3;
            active_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ENABLE:     enable_reg     <= cfg_data[0];
                CFG_BRIGHTNESS: brightness_reg <= cfg_data[6:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                CFG_WAKE_COUNT: wake_count_reg <= cfg_data[1:0];
                CFG_ACTIVE:     active_reg     <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg   <= '0;
            shown_reg  <= '0;
            total_reg  <= '0;
            page_reg   <= '0;
            ptimer_reg <= '0;
            last_reg   <= '0;
            light_reg  <= 1'b1;
            for (int i = 0; i < SCAN_N; i++) begin
                pressed_reg[i] <= 1'b0;
                btimer_reg[i]  <= '0;
            end
        end else if (advance) begin
            time_reg   <= time_next;
            shown_reg  <= shown_next;
            total_reg  <= total_next;
            page_reg   <= page_next;
            ptimer_reg <= ptimer_next;
            last_reg   <= last_next;
            light_reg  <= light_next;
            for (int i = 0; i < SCAN_N; i++) begin
                pressed_reg[i] <= pressed_next[i];
                btimer_reg[i]  <= btimer_next[i];
            end
        end
    end

    assign timeout_ms = 22'(timeout_reg) * 22'(MS_PER_SECOND);

    always_comb begin
        logic hit;
        logic raw;
        hit         = 1'b0;
        raw         = 1'b0;
        refresh     = 1'b0;
        time_next   = time_reg + 32'd1;
        shown_next  = shown_reg;
        total_next  = total_reg;
        page_next   = page_reg;
        ptimer_next = ptimer_reg;
        last_next   = last_reg;
        light_next  = light_reg;
        for (int i = 0; i < SCAN_N; i++) begin
            pressed_next[i] = pressed_reg[i];
            btimer_next[i]  = btimer_reg[i];
        end
        mask = in_data_reg.test_mode ? '1 : {in_data_reg.fault_aux, in_data_reg.fault_bus};

        if (enable_reg) begin
            // pager
            if (mask != shown_reg || in_data_reg.rebuild) begin
                shown_next  = mask;
                page_next   = '0;
                ptimer_next = time_reg;
                total_next  = 5'($countones(mask));
                if (total_next != 5'd0) begin
                    light_next = 1'b1;
                    last_next  = time_reg;
                end
                refresh = 1'b1;
            end else if (total_reg > 5'(PAGE_SIZE)
                         && (time_reg - ptimer_reg) >= 32'(PAGE_MS)) begin
                ptimer_next = time_reg;
                page_next   = (3'(page_reg) + 3'd1 >= pages_of(total_reg)) ?
                              2'd0 : page_reg + 2'd1;
                refresh     = 1'b1;
            end

            // backlight
            if (timeout_reg == '0 || in_data_reg.test_mode
                || in_data_reg.fault_bus != '0 || in_data_reg.fault_aux != '0) begin
                light_next = 1'b1;
                last_next  = time_reg;
            end else begin
                for (int i = 0; i < SCAN_N; i++) begin
                    raw = (in_data_reg.wake_levels[i] == active_reg[i]);
                    if (i < int'(wake_count_reg) && raw != pressed_reg[i]
                        && (time_reg - btimer_reg[i]) >= 32'(DEBOUNCE_MS)) begin
                        btimer_next[i]  = time_reg;
                        pressed_next[i] = raw;
                        if (raw) begin
                            hit = 1'b1;
                        end
                    end
                end
                if (hit) begin
                    light_next = 1'b1;
                    last_next  = time_reg;
                end else if (light_next && (time_reg - last_next) >= 32'(timeout_ms)) begin
                    light_next = 1'b0;
                end
            end
        end else begin
            light_next = 1'b0;
        end
    end

    apbt_page_view u_page_view (
        .mask  (shown_next),
        .page  (page_next),
        .total (total_next),
        .view  (view)
    );

    always_comb begin
        if (brightness_reg < 7'(BRIGHT_MIN)) begin
            bright = 7'(BRIGHT_MIN);
        end else if (brightness_reg > 7'(BRIGHT_MAX)) begin
            bright = 7'(BRIGHT_MAX);
        end else begin
            bright = brightness_reg;
        end
        m_data_next.backlight_level = light_next ? bright : 7'd0;
        m_data_next.alarm_shown     = view.alarm_shown;
        m_data_next.alarm_refresh   = refresh;
        m_data_next.title_code      = view.title_code;
        m_data_next.page_index      = view.page_index;
        m_data_next.page_total      = view.page_total;
        m_data_next.entries_on_page = view.entries_on_page;
        m_data_next.entry_first     = view.entry_first;
        m_data_next.entry_second    = view.entry_second;
        m_data_next.entry_third     = view.entry_third;
        m_data_next.entry_fourth    = view.entry_fourth;
    end

endmodule

@@ hdl/apbt_checker.sv @@
module apbt_checker import apbt_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // no result word right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // page number and alarm flag agree with page count
    a_pages: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.page_total == 3'd0 && m_data.page_index == 2'd0
                      && !m_data.alarm_shown)
                  || (m_data.page_total != 3'd0 && {1'b0, m_data.page_index} < m_data.page_total
                      && m_data.alarm_shown)))
        else $error("page index, page count and alarm flag disagree");

    // every page but the last is full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.page_total != 3'd0
        && ({1'b0, m_data.page_index} + 3'd1) < m_data.page_total
        |-> m_data.entries_on_page == 3'(PAGE_SIZE))
        else $error("page before the last is not full");

    // an empty page has the bus title and zero first and fourth entries
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.entries_on_page == 3'd0
        |-> m_data.title_code == TITLE_BUS && m_data.entry_first == 4'd0
            && m_data.entry_fourth == 4'd0)
        else $error("empty page carries entries");

endmodule

bind alarm_pager_backlight_timeout apbt_checker u_apbt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ test/tb.sv @@
module tb;
    import apbt_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef enum {MIX_ROUND, QUIET_ROUND, HOLD_ROUND} round_t;

    class alarm_page_board;
        out_word_t   expected_q[$];
        int unsigned checked;
        int unsigned errors;

        bit        en;
        bit [6:0]  bright;
        bit [11:0] tmo;
        bit [1:0]  nwake;
        bit [2:0]  act_lvl;

        bit [31:0] now_ms;
        bit [31:0] page_start;
        bit [31:0] last_touch;
        bit [15:0] mask_shown;
        bit [4:0]  n_alarms;
        bit [1:0]  page;
        bit        lit;
        bit [2:0]  btn_down;
        bit [31:0] btn_stamp[3];

        function new();
            en = 1'b1;
            bright = 7'd100;
            tmo = '0;
            nwake = 2'd3;
            act_lvl = '0;
            now_ms = '0;
            page_start = '0;
            last_touch = '0;
            mask_shown = '0;
            n_alarms = '0;
            page = '0;
            lit = 1'b1;
            btn_down = '0;
            foreach (btn_stamp[i]) btn_stamp[i] = '0;
            checked = 0;
            errors = 0;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10) $display("%s", what);
        endfunction

        function void write_reg(logic [2:0] idx, logic [11:0] val);
            case (cfg_reg_t'(idx))
                CFG_ENABLE:     en = val[0];
                CFG_BRIGHTNESS: bright = val[6:0];
                CFG_TIMEOUT:    tmo = val;
                CFG_WAKE_COUNT: nwake = val[1:0];
                CFG_ACTIVE:     act_lvl = val[2:0];
                default: ;
            endcase
        endfunction

        function void wake_at(bit [31:0] t);
            last_touch = t;
            lit = 1'b1;
        endfunction

        // debounced scan, true on an accepted change to pressed
        function bit scan_wake(bit [31:0] t, bit [2:0] levels);
            bit hit;
            bit raw;
            int lim;
            hit = 1'b0;
            lim = (int'(nwake) > WAKE_BUTTONS_DEF) ? WAKE_BUTTONS_DEF : int'(nwake);
            if (lim > SCAN_MAX) lim = SCAN_MAX;
            for (int i = 0; i < lim; i++) begin
                raw = (levels[i] == act_lvl[i]);
                if (raw != btn_down[i] && (t - btn_stamp[i]) >= 32'(DEBOUNCE_MS_DEF)) begin
                    btn_stamp[i] = t;
                    btn_down[i] = raw;
                    if (raw) hit = 1'b1;
                end
            end
            return hit;
        endfunction

        function void note_input(in_word_t w);
            bit [31:0] t;
            bit [15:0] m;
            bit        refresh;
            out_word_t e;
            int        first_idx;
            int        n;
            int        idx;
            int        lvl;
            bit        side0;
            bit        mixed;
            bit [3:0]  slot[4];
            t = now_ms;
            refresh = 1'b0;
            if (en) begin
                m = w.test_mode ? 16'hFFFF : {w.fault_aux, w.fault_bus};
                if (m != mask_shown || w.rebuild) begin
                    mask_shown = m;
                    page = '0;
                    page_start = t;
                    n_alarms = 5'($countones(m));
                    if (n_alarms != 0) wake_at(t);
                    refresh = 1'b1;
                end else if (int'(n_alarms) > PAGE_SIZE && (t - page_start) >= 32'(PAGE_MS)) begin
                    page_start = t;
                    page = 2'((int'(page) + 1) % ((int'(n_alarms) + PAGE_SIZE - 1) / PAGE_SIZE));
                    refresh = 1'b1;
                end
                if (tmo == 0 || w.test_mode || w.fault_bus != 0 || w.fault_aux != 0) begin
                    wake_at(t);
                end else if (scan_wake(t, w.wake_levels)) begin
                    wake_at(t);
                end else if (lit && (t - last_touch) >= 32'(tmo) * 32'(MS_PER_SECOND)) begin
                    lit = 1'b0;
                end
            end else begin
                lit = 1'b0;
            end

            // entries of the current page, in ascending bit order
            first_idx = int'(page) * PAGE_SIZE;
            n = 0;
            idx = 0;
            side0 = 1'b0;
            mixed = 1'b0;
            foreach (slot[i]) slot[i] = '0;
            for (int b = 0; b < ALARM_BITS; b++) begin
                if (mask_shown[b]) begin
                    if (idx >= first_idx && n < PAGE_SIZE) begin
                        if (n == 0) side0 = (b >= SIDE_BITS);
                        else if ((b >= SIDE_BITS) != side0) mixed = 1'b1;
                        slot[n] = 4'(b);
                        n++;
                    end
                    idx++;
                end
            end

            lvl = (bright < BRIGHT_MIN) ? BRIGHT_MIN : (bright > BRIGHT_MAX) ? BRIGHT_MAX : bright;
            e = '0;
            e.backlight_level = lit ? 7'(lvl) : 7'd0;
            e.alarm_shown = (n_alarms != 0);
            e.alarm_refresh = refresh;
            if (n == 0) e.title_code = TITLE_BUS;
            else if (mixed) e.title_code = TITLE_MIXED;
            else e.title_code = side0 ? TITLE_AUX : TITLE_BUS;
            e.page_index = page;
            e.page_total = 3'((int'(n_alarms) + PAGE_SIZE - 1) / PAGE_SIZE);
            e.entries_on_page = 3'(n);
            e.entry_first = slot[0];
            e.entry_second = slot[1];
            e.entry_third = slot[2];
            e.entry_fourth = slot[3];
            expected_q.push_back(e);
            now_ms = t + 1;
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            string     bad;
            checked++;
            if (expected_q.size() == 0) begin
                flag($sformatf("result word %h arrived with nothing pending", got));
                return;
            end
            want = expected_q.pop_front();
            bad = "";
            if (got.backlight_level !== want.backlight_level) bad = {bad, " backlight_level"};
            if (got.alarm_shown !== want.alarm_shown) bad = {bad, " alarm_shown"};
            if (got.alarm_refresh !== want.alarm_refresh) bad = {bad, " alarm_refresh"};
            if (got.title_code !== want.title_code) bad = {bad, " title_code"};
            if (got.page_index !== want.page_index) bad = {bad, " page_index"};
            if (got.page_total !== want.page_total) bad = {bad, " page_total"};
            if (got.entries_on_page !== want.entries_on_page) bad = {bad, " entries_on_page"};
            if (got.entry_first !== want.entry_first) bad = {bad, " entry_first"};
            if (got.entry_second !== want.entry_second) bad = {bad, " entry_second"};
            if (got.entry_third !== want.entry_third) bad = {bad, " entry_third"};
            if (got.entry_fourth !== want.entry_fourth) bad = {bad, " entry_fourth"};
            if (bad != "")
                flag($sformatf("result %0d mismatch in%s: expected %h, got %h",
                               checked - 1, bad, want, got));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    alarm_page_board board;
    int unsigned     words_sent = 0;
    int              stall_cycles = 0;
    bit              burst = 1'b0;

    alarm_pager_backlight_timeout dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= burst || ($urandom_range(99) >= 19);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) board.note_input(s_data);
            if (m_valid && m_ready) board.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic in_word_t tick_word(bit [7:0] bus, bit [7:0] aux, bit tm, bit rb,
                                           bit [2:0] lv);
        in_word_t w;
        w.fault_bus = bus;
        w.fault_aux = aux;
        w.test_mode = tm;
        w.rebuild = rb;
        w.wake_levels = lv;
        return w;
    endfunction

    function automatic bit [15:0] pick_faults();
        case ($urandom_range(5))
            0: return '0;
            1: return 16'(1) << $urandom_range(15);
            2: return 16'($urandom);
            3: return 16'($urandom & $urandom & $urandom);
            4: return {8'h00, 8'($urandom)} << (8 * $urandom_range(1));
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic send_word(input in_word_t w);
        while (!burst && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.checked < words_sent) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 12'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic run_phase(input round_t round, input int words);
        int        done;
        int        seg;
        int        rate;
        int        rb_pct;
        bit [15:0] f;
        bit [2:0]  lv;
        bit        tm;
        cfg_valid <= 1'b0;
        burst = (round == HOLD_ROUND);
        done = 0;
        lv = 3'($urandom);
        while (done < words) begin
            case (round)
                MIX_ROUND: begin
                    seg = $urandom_range(1, 60);
                    f = pick_faults();
                    tm = ($urandom_range(9) == 0);
                    rate = 20;
                    rb_pct = 3;
                end
                QUIET_ROUND: begin
                    // long calm stretches let the light time out, short bursts of faults
                    if ($urandom_range(9) == 0) begin
                        seg = $urandom_range(1, 8);
                        f = pick_faults();
                        tm = ($urandom_range(4) == 0);
                    end else begin
                        seg = $urandom_range(20, 1400);
                        f = '0;
                        tm = 1'b0;
                    end
                    case ($urandom_range(3))
                        0, 1: rate = 0;
                        2: rate = 1;
                        default: rate = 5;
                    endcase
                    rb_pct = 1;
                end
                default: begin
                    seg = words;
                    f = '0;
                    tm = 1'b1;
                    rate = 20;
                    rb_pct = 0;
                end
            endcase
            for (int k = 0; k < seg && done < words; k++) begin
                if ($urandom_range(99) < rate) lv = lv ^ 3'(1 << $urandom_range(2));
                if (round == HOLD_ROUND) f = 16'($urandom);
                send_word(tick_word(f[7:0], f[15:8], tm, $urandom_range(99) < rb_pct, lv));
                done++;
            end
        end
        burst = 1'b0;
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(tick_word(8'h00, 8'h00, 1'b0, 1'b0, 3'd0));
        send_word(tick_word(8'h01, 8'h00, 1'b0, 1'b0, 3'd7));
        send_word(tick_word(8'h00, 8'h80, 1'b0, 1'b0, 3'd0));
        send_word(tick_word(8'h80, 8'h01, 1'b0, 1'b0, 3'd7));
        send_word(tick_word(8'hFF, 8'h00, 1'b0, 1'b0, 3'd1));
        send_word(tick_word(8'h00, 8'hFF, 1'b0, 1'b0, 3'd2));
        send_word(tick_word(8'hFF, 8'hFF, 1'b0, 1'b0, 3'd4));
        send_word(tick_word(8'hFF, 8'hFF, 1'b0, 1'b1, 3'd4));
        send_word(tick_word(8'h0F, 8'h00, 1'b0, 1'b0, 3'd0));
        send_word(tick_word(8'h1F, 8'h00, 1'b0, 1'b0, 3'd0));
        send_word(tick_word(8'h00, 8'h00, 1'b1, 1'b0, 3'd7));
        send_word(tick_word(8'h55, 8'hAA, 1'b1, 1'b1, 3'd7));
        send_word(tick_word(8'h55, 8'hAA, 1'b0, 1'b0, 3'd5));
        send_word(tick_word(8'h00, 8'h00, 1'b0, 1'b1, 3'd2));
        send_word(tick_word(8'h00, 8'h00, 1'b0, 1'b0, 3'd7));
        send_word(tick_word(8'hAA, 8'h55, 1'b0, 1'b0, 3'd0));
        send_word(tick_word(8'hF0, 8'h0F, 1'b0, 1'b1, 3'd3));

        drain();
        write_reg(CFG_BRIGHTNESS, 0);
        run_phase(MIX_ROUND, 150);

        drain();
        write_reg(CFG_BRIGHTNESS, 127);
        write_reg(CFG_TIMEOUT, 1);
        write_reg(CFG_ACTIVE, 3'b101);
        run_phase(QUIET_ROUND, 800);

        drain();
        write_reg(CFG_WAKE_COUNT, 0);
        write_reg(CFG_ACTIVE, 3'b111);
        write_reg(CFG_BRIGHTNESS, 1);
        run_phase(QUIET_ROUND, 150);

        drain();
        write_reg(CFG_WAKE_COUNT, 1);
        write_reg(CFG_ACTIVE, 3'b000);
        write_reg(CFG_BRIGHTNESS, 100);
        run_phase(QUIET_ROUND, 150);

        drain();
        write_reg(CFG_WAKE_COUNT, 2);
        write_reg(CFG_ACTIVE, $urandom_range(7));
        run_phase(QUIET_ROUND, 150);

        drain();
        write_reg(CFG_WAKE_COUNT, 3);
        write_reg(CFG_TIMEOUT, 3600);
        run_phase(MIX_ROUND, 80);

        drain();
        write_reg(CFG_TIMEOUT, 4095);
        write_reg(CFG_BRIGHTNESS, $urandom_range(2, 99));
        run_phase(MIX_ROUND, 80);

        drain();
        write_reg(CFG_ENABLE, 0);
        run_phase(MIX_ROUND, 80);

        // steady full mask with both sides never idling
        drain();
        write_reg(CFG_ENABLE, 1);
        write_reg(CFG_TIMEOUT, 0);
        run_phase(HOLD_ROUND, 300);

        drain();
        write_reg(CFG_TIMEOUT, 2);
        write_reg(CFG_BRIGHTNESS, 100);
        run_phase(MIX_ROUND, 100);

        drain();
        repeat (20) @(posedge aclk);
        if (board.expected_q.size() != 0)
            board.flag($sformatf("%0d expected words never arrived", board.expected_q.size()));
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
